>>> rtl/core/simd_fast_mersenne_twister_assert.svh
// assertion macros for the sfmt generator
// expects clk_i and rst_ni in the scope of each use; no other dependencies
`ifndef SIMD_FAST_MERSENNE_TWISTER_ASSERT_SVH
`define SIMD_FAST_MERSENNE_TWISTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SFMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen outside reset
`define SFMT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SFMT_ASSERT(label, prop, msg)
`define SFMT_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> rtl/core/sfmt_pkg.sv
// shared types and constants of the sfmt generator
// used by sfmt_ctrl, sfmt_datapath and the top level; no dependencies
`timescale 1ns / 1ps

package sfmt_pkg;

  // state geometry
  localparam int unsigned WORDS         = 156;
  localparam int unsigned MIDDLE_OFFSET = 122;
  localparam int unsigned LANES         = 4 * WORDS;
  localparam int unsigned WORD_AW       = $clog2(WORDS);
  localparam int unsigned POS_W         = $clog2(LANES + 1);

  // field widths
  localparam int unsigned LANE_W   = 32;
  localparam int unsigned WORD_W   = 4 * LANE_W;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // register reset values
  localparam logic [SHIFT_W-1:0] LANE_LEFT_SHIFT_RST  = 5'd18;
  localparam logic [SHIFT_W-1:0] WORD_LEFT_BYTES_RST  = 5'd1;
  localparam logic [SHIFT_W-1:0] LANE_RIGHT_SHIFT_RST = 5'd11;
  localparam logic [SHIFT_W-1:0] WORD_RIGHT_BYTES_RST = 5'd1;
  localparam logic [LANE_W-1:0]  MASK_LANE0_RST = 32'hdfffffef;
  localparam logic [LANE_W-1:0]  MASK_LANE1_RST = 32'hddfecb7f;
  localparam logic [LANE_W-1:0]  MASK_LANE2_RST = 32'hbffaffff;
  localparam logic [LANE_W-1:0]  MASK_LANE3_RST = 32'hbffffff6;

  // request codes
  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_DRAW = 1'b1
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LANE_LEFT_SHIFT  = 3'd0,
    CFG_WORD_LEFT_BYTES  = 3'd1,
    CFG_LANE_RIGHT_SHIFT = 3'd2,
    CFG_WORD_RIGHT_BYTES = 3'd3,
    CFG_MASK_LANE0       = 3'd4,
    CFG_MASK_LANE1       = 3'd5,
    CFG_MASK_LANE2       = 3'd6,
    CFG_MASK_LANE3       = 3'd7
  } cfg_reg_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GUARD_SCAN,
    ST_GUARD_END,
    ST_PRIME,
    ST_PRIME_LOAD,
    ST_REGEN_RD,
    ST_REGEN_WR,
    ST_FETCH,
    ST_DELIVER
  } ctrl_state_e;

  // read address selection
  typedef enum logic [1:0] {
    RD_COUNT,
    RD_PRIME,
    RD_POS
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    rd_sel_e rd_sel;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    seed_wr;
    logic    acc_clr;
    logic    acc_en;
    logic    guard_fix;
    logic    guard_clr;
    logic    prime_load;
    logic    regen_wr;
    logic    pos_clr;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic guard;
    logic exhausted;
    logic cnt_last;
    logic any_nz;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/core/simd_fast_mersenne_twister.sv
// SFMT generator: a draw runs fetch, registered read of the lane store and output
// load when the buffer holds words; when it is exhausted, regeneration runs first,
// one 128-bit word at a time through the two read ports of the lane store (read a
// and the middle word, then compute and write); and the first draw after seeding
// is preceded by the zero scan (one word read per cycle). Configuration writes
// are always ready and belong in idle periods only.
// depends on sfmt_pkg, sfmt_ctrl and sfmt_datapath
`timescale 1ns / 1ps

module simd_fast_mersenne_twister (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [sfmt_pkg::INDEX_W-1:0]      lane_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]       seed_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sfmt_pkg::LANE_W-1:0]       rand_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfmt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]       cfg_data_i
);

  sfmt_pkg::ctrl_cmd_t cmd;
  sfmt_pkg::ctrl_sts_t sts;

  // configuration registers take a word every cycle
  assign cfg_ready_o = 1'b1;

  // sequencer
  sfmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, recurrence and output
  sfmt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .lane_index_i (lane_index_i),
    .seed_word_i  (seed_word_i),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rand_word_o  (rand_word_o)
  );

endmodule

>>> rtl/core/sfmt_ctrl.sv
// sequencer of the sfmt generator: seed writes, zero guard, regeneration, draws
// depends on sfmt_pkg and simd_fast_mersenne_twister_assert.svh
`timescale 1ns / 1ps
`include "simd_fast_mersenne_twister_assert.svh"

module sfmt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  sfmt_pkg::ctrl_sts_t  sts_i,
  output sfmt_pkg::ctrl_cmd_t  cmd_o
);

  sfmt_pkg::ctrl_state_e state_q, state_d;
  logic in_acc;
  logic is_draw;

  // words are taken only while idle
  assign in_stall_o = (state_q != sfmt_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == sfmt_pkg::ST_IDLE);
  assign is_draw    = (req_type_i == sfmt_pkg::REQ_DRAW);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfmt_pkg::ST_IDLE: begin
        if (in_acc && is_draw) begin
          priority if (sts_i.guard) state_d = sfmt_pkg::ST_GUARD_SCAN;
          else if (sts_i.exhausted) state_d = sfmt_pkg::ST_PRIME;
          else                      state_d = sfmt_pkg::ST_FETCH;
        end
      end
      sfmt_pkg::ST_GUARD_SCAN: begin
        if (sts_i.cnt_last) state_d = sfmt_pkg::ST_GUARD_END;
      end
      sfmt_pkg::ST_GUARD_END: begin
        state_d = sts_i.exhausted ? sfmt_pkg::ST_PRIME : sfmt_pkg::ST_FETCH;
      end
      sfmt_pkg::ST_PRIME:      state_d = sfmt_pkg::ST_PRIME_LOAD;
      sfmt_pkg::ST_PRIME_LOAD: state_d = sfmt_pkg::ST_REGEN_WR;
      sfmt_pkg::ST_REGEN_RD:   state_d = sfmt_pkg::ST_REGEN_WR;
      sfmt_pkg::ST_REGEN_WR: begin
        state_d = sts_i.cnt_last ? sfmt_pkg::ST_FETCH : sfmt_pkg::ST_REGEN_RD;
      end
      sfmt_pkg::ST_FETCH: state_d = sfmt_pkg::ST_DELIVER;
      sfmt_pkg::ST_DELIVER: begin
        if (sts_i.out_free) state_d = sfmt_pkg::ST_IDLE;
      end
      default: state_d = sfmt_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = sfmt_pkg::RD_COUNT;
    unique case (state_q)
      sfmt_pkg::ST_IDLE: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.seed_wr = in_acc && !is_draw;
      end
      sfmt_pkg::ST_GUARD_SCAN: begin
        // first cycle has no read data yet
        cmd_o.cnt_inc = 1'b1;
        cmd_o.acc_clr = !sts_i.cnt_last && (state_d == state_q) && 1'b0;
        cmd_o.acc_en  = 1'b1;
      end
      sfmt_pkg::ST_GUARD_END: begin
        cmd_o.guard_fix = !sts_i.any_nz;
        cmd_o.guard_clr = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
      end
      sfmt_pkg::ST_PRIME: begin
        cmd_o.rd_sel = sfmt_pkg::RD_PRIME;
      end
      sfmt_pkg::ST_PRIME_LOAD: begin
        cmd_o.prime_load = 1'b1;
      end
      sfmt_pkg::ST_REGEN_RD: begin
        cmd_o.rd_sel = sfmt_pkg::RD_COUNT;
      end
      sfmt_pkg::ST_REGEN_WR: begin
        cmd_o.regen_wr = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        cmd_o.pos_clr  = sts_i.cnt_last;
      end
      sfmt_pkg::ST_FETCH: begin
        cmd_o.rd_sel = sfmt_pkg::RD_POS;
      end
      sfmt_pkg::ST_DELIVER: begin
        cmd_o.rd_sel   = sfmt_pkg::RD_POS;
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // draw with a pending guard always scans first
  `SFMT_ASSERT(a_guard_first, (in_acc && is_draw && sts_i.guard) |=> (state_q == sfmt_pkg::ST_GUARD_SCAN), "guarded draw skipped the zero scan")
  // read position restarts only on the last regenerated word
  `SFMT_ASSERT(a_pos_clr_last, cmd_o.pos_clr |-> (cmd_o.regen_wr && sts_i.cnt_last), "read position cleared mid regeneration")
  // a delivered word returns the sequencer to idle
  `SFMT_ASSERT(a_deliver_idle, (state_q == sfmt_pkg::ST_DELIVER && sts_i.out_free) |=> (state_q == sfmt_pkg::ST_IDLE), "sequencer stuck after delivery")

endmodule

>>> rtl/core/sfmt_datapath.sv
// lane store, recurrence unit, configuration registers and output register
// depends on sfmt_pkg and simd_fast_mersenne_twister_assert.svh
`timescale 1ns / 1ps
`include "simd_fast_mersenne_twister_assert.svh"

module sfmt_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sfmt_pkg::ctrl_cmd_t                   cmd_i,
  output sfmt_pkg::ctrl_sts_t                   sts_o,
  input  logic [sfmt_pkg::INDEX_W-1:0]          lane_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]           seed_word_i,
  input  logic                                  cfg_valid_i,
  input  logic [sfmt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]           cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sfmt_pkg::LANE_W-1:0]           rand_word_o
);

  localparam int unsigned AW = sfmt_pkg::WORD_AW;
  localparam int unsigned WW = sfmt_pkg::WORD_W;
  localparam int unsigned LW = sfmt_pkg::LANE_W;
  localparam int unsigned PW = sfmt_pkg::POS_W;
  localparam int unsigned SW = sfmt_pkg::SHIFT_W;

  // configuration registers
  logic [SW-1:0] ls_q, lb_q, rs_q, rb_q;
  logic [LW-1:0] mask_q [4];

  // lane store and its ports
  logic [WW-1:0] lane_mem_q [sfmt_pkg::WORDS];
  logic [WW-1:0] rdata_a_q, rdata_b_q;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [WW-1:0] wdata;
  logic [3:0]    wlane;
  logic          we;

  // sequencing state
  logic [AW-1:0] cnt_q, bptr_q;
  logic [PW-1:0] read_pos_q;
  logic          guard_q;
  logic          any_q;
  logic [WW-1:0] c_q, d_q;
  logic [WW-1:0] new_word;
  logic          seed_in_range;
  logic          out_valid_q;
  logic [LW-1:0] out_word_q;
  logic          out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q      <= sfmt_pkg::LANE_LEFT_SHIFT_RST;
      lb_q      <= sfmt_pkg::WORD_LEFT_BYTES_RST;
      rs_q      <= sfmt_pkg::LANE_RIGHT_SHIFT_RST;
      rb_q      <= sfmt_pkg::WORD_RIGHT_BYTES_RST;
      mask_q[0] <= sfmt_pkg::MASK_LANE0_RST;
      mask_q[1] <= sfmt_pkg::MASK_LANE1_RST;
      mask_q[2] <= sfmt_pkg::MASK_LANE2_RST;
      mask_q[3] <= sfmt_pkg::MASK_LANE3_RST;
    end else if (cfg_valid_i) begin
      unique case (sfmt_pkg::cfg_reg_e'(cfg_index_i))
        sfmt_pkg::CFG_LANE_LEFT_SHIFT:  ls_q      <= cfg_data_i[SW-1:0];
        sfmt_pkg::CFG_WORD_LEFT_BYTES:  lb_q      <= cfg_data_i[SW-1:0];
        sfmt_pkg::CFG_LANE_RIGHT_SHIFT: rs_q      <= cfg_data_i[SW-1:0];
        sfmt_pkg::CFG_WORD_RIGHT_BYTES: rb_q      <= cfg_data_i[SW-1:0];
        sfmt_pkg::CFG_MASK_LANE0:       mask_q[0] <= cfg_data_i;
        sfmt_pkg::CFG_MASK_LANE1:       mask_q[1] <= cfg_data_i;
        sfmt_pkg::CFG_MASK_LANE2:       mask_q[2] <= cfg_data_i;
        sfmt_pkg::CFG_MASK_LANE3:       mask_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // read address selection
  always_comb begin
    unique case (cmd_i.rd_sel)
      sfmt_pkg::RD_PRIME: begin
        raddr_a = AW'(sfmt_pkg::WORDS - 2);
        raddr_b = AW'(sfmt_pkg::WORDS - 1);
      end
      sfmt_pkg::RD_POS: begin
        raddr_a = AW'(read_pos_q >> 2);
        raddr_b = AW'(read_pos_q >> 2);
      end
      default: begin
        raddr_a = cnt_q;
        raddr_b = bptr_q;
      end
    endcase
  end

  // recurrence for one 128-bit word
  always_comb begin
    logic [WW-1:0] x, y, t;
    x = rdata_a_q << {lb_q, 3'b000};
    y = c_q >> {rb_q, 3'b000};
    for (int l = 0; l < 4; l++) begin
      t[l*LW +: LW] = ((rdata_b_q[l*LW +: LW] >> rs_q) & mask_q[l])
                    ^ (d_q[l*LW +: LW] << ls_q);
    end
    new_word = rdata_a_q ^ x ^ y ^ t;
  end

  // write port selection
  assign seed_in_range = (32'(lane_index_i) < 32'(sfmt_pkg::LANES));
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = new_word;
    wlane = 4'b1111;
    priority if (cmd_i.seed_wr) begin
      we    = seed_in_range;
      waddr = AW'(lane_index_i >> 2);
      wdata = {4{seed_word_i}};
      wlane = 4'b0001 << lane_index_i[1:0];
    end else if (cmd_i.guard_fix) begin
      we    = 1'b1;
      waddr = '0;
      wdata = WW'(1);
      wlane = 4'b0001;
    end else if (cmd_i.regen_wr) begin
      we    = 1'b1;
    end
  end

  // lane store, registered reads
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      if (we && wlane[l]) lane_mem_q[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
    end
    rdata_a_q <= lane_mem_q[raddr_a];
    rdata_b_q <= lane_mem_q[raddr_b];
  end

  // word counter and middle pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bptr_q <= AW'(sfmt_pkg::MIDDLE_OFFSET);
    end else if (cmd_i.cnt_clr) begin
      cnt_q  <= '0;
      bptr_q <= AW'(sfmt_pkg::MIDDLE_OFFSET);
    end else if (cmd_i.cnt_inc) begin
      cnt_q  <= (cnt_q == AW'(sfmt_pkg::WORDS - 1)) ? '0 : cnt_q + AW'(1);
      bptr_q <= (bptr_q == AW'(sfmt_pkg::WORDS - 1)) ? '0 : bptr_q + AW'(1);
    end
  end

  // read position and zero guard flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q <= PW'(sfmt_pkg::LANES);
      guard_q    <= 1'b0;
    end else begin
      if (cmd_i.seed_wr) begin
        read_pos_q <= PW'(sfmt_pkg::LANES);
        guard_q    <= 1'b1;
      end else begin
        if (cmd_i.guard_clr) guard_q <= 1'b0;
        priority if (cmd_i.pos_clr) read_pos_q <= '0;
        else if (cmd_i.out_load)    read_pos_q <= read_pos_q + PW'(1);
      end
    end
  end

  // nonzero accumulation over the scan, read data follows its address in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      if (cnt_q == '0) any_q <= 1'b0;
      else             any_q <= any_q | (rdata_a_q != '0);
    end else if (cmd_i.acc_clr) begin
      any_q <= 1'b0;
    end
  end

  // previous two words of the recurrence
  always_ff @(posedge clk_i) begin
    if (cmd_i.prime_load) begin
      c_q <= rdata_a_q;
      d_q <= rdata_b_q;
    end else if (cmd_i.regen_wr) begin
      c_q <= d_q;
      d_q <= new_word;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_word_q <= rdata_a_q[{read_pos_q[1:0], 5'b00000} +: LW];
  end

  assign out_valid_o = out_valid_q;
  assign rand_word_o = out_word_q;

  // status
  assign sts_o.guard     = guard_q;
  assign sts_o.exhausted = (read_pos_q == PW'(sfmt_pkg::LANES));
  assign sts_o.cnt_last  = (cnt_q == AW'(sfmt_pkg::WORDS - 1));
  assign sts_o.any_nz    = any_q | (rdata_a_q != '0);
  assign sts_o.out_free  = out_free;

  // read position never runs past the exhausted mark
  `SFMT_ASSERT(a_pos_range, (read_pos_q <= PW'(sfmt_pkg::LANES)), "read position out of range")
  // seed writes never collide with internal writes
  `SFMT_ASSERT_NEVER(a_wr_collide, (cmd_i.seed_wr && (cmd_i.regen_wr || cmd_i.guard_fix)), "write port collision")
  // a new word never overwrites one still waiting
  `SFMT_ASSERT(a_out_free, cmd_i.out_load |-> out_free, "output word overwritten")

endmodule

>>> bench/sfmt_draw_checker.sv
// watches the request, result and register channels of the sfmt generator and checks every drawn word
// keeps its own copy of the lane store; depends on sfmt_pkg only
`timescale 1ns / 1ps

module sfmt_draw_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           req_type_i,
  input  logic [sfmt_pkg::INDEX_W-1:0]   lane_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]    seed_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [sfmt_pkg::LANE_W-1:0]    rand_word_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [sfmt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sfmt_pkg::LANE_W-1:0]    cfg_data_i,
  output int                             fail_count_o,
  output int                             words_pending_o,
  output int                             words_checked_o,
  output int                             refills_o
);
  import sfmt_pkg::*;

  localparam int MAX_PRINTED = 100;

  // mirrored generator state
  logic [LANE_W-1:0]  lanes [LANES];
  int unsigned        next_lane;
  logic               zero_guard;
  logic [SHIFT_W-1:0] lshift, lbytes, rshift, rbytes;
  logic [LANE_W-1:0]  lane_mask [4];

  // words owed to the receiver, oldest first
  logic [LANE_W-1:0]  owed_words [$];
  logic [LANE_W-1:0]  oldest_word;

  int mismatches;
  int checked;
  int refills;
  int pending;

  assign fail_count_o    = mismatches;
  assign words_pending_o = pending;
  assign words_checked_o = checked;
  assign refills_o       = refills;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic logic [4*LANE_W-1:0] word_at(input int unsigned wi);
    return {lanes[wi*4+3], lanes[wi*4+2], lanes[wi*4+1], lanes[wi*4]};
  endfunction

  // in-place regeneration, word by word, later words see updated neighbours
  function automatic void refill_lanes();
    logic [4*LANE_W-1:0] a, b, c, d, x, y;
    int unsigned ib, ic, id;
    for (int unsigned i = 0; i < WORDS; i++) begin
      ib = (i + MIDDLE_OFFSET) % WORDS;
      ic = (i + WORDS - 2) % WORDS;
      id = (i + WORDS - 1) % WORDS;
      a = word_at(i);
      b = word_at(ib);
      c = word_at(ic);
      d = word_at(id);
      x = (lbytes >= 16) ? '0 : a << (8 * lbytes);
      y = (rbytes >= 16) ? '0 : c >> (8 * rbytes);
      for (int l = 0; l < 4; l++) begin
        lanes[i*4+l] = a[l*LANE_W +: LANE_W] ^ x[l*LANE_W +: LANE_W]
                     ^ ((b[l*LANE_W +: LANE_W] >> rshift) & lane_mask[l])
                     ^ y[l*LANE_W +: LANE_W] ^ (d[l*LANE_W +: LANE_W] << lshift);
      end
    end
  endfunction

  // effect of one accepted request, queuing the word a draw returns
  function automatic void predict_request(input logic req, input logic [INDEX_W-1:0] idx,
                                          input logic [LANE_W-1:0] word);
    logic any_set;
    if (req_e'(req) == REQ_SEED) begin
      if (idx < LANES) lanes[idx] = word;
      next_lane  = LANES;
      zero_guard = 1'b1;
    end else begin
      // all-zero state left by seeding gets lane 0 forced to one
      if (zero_guard) begin
        any_set = 1'b0;
        for (int k = 0; k < LANES; k++) any_set |= (lanes[k] != '0);
        if (!any_set) lanes[0] = 32'd1;
        zero_guard = 1'b0;
      end
      if (next_lane >= LANES) begin
        refill_lanes();
        next_lane = 0;
        refills++;
      end
      owed_words.push_back(lanes[next_lane]);
      next_lane++;
    end
  endfunction

  // register write, prediction and comparison on each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANES; k++) lanes[k] = '0;
      next_lane    = LANES;
      zero_guard   = 1'b0;
      lshift       = LANE_LEFT_SHIFT_RST;
      lbytes       = WORD_LEFT_BYTES_RST;
      rshift       = LANE_RIGHT_SHIFT_RST;
      rbytes       = WORD_RIGHT_BYTES_RST;
      lane_mask[0] = MASK_LANE0_RST;
      lane_mask[1] = MASK_LANE1_RST;
      lane_mask[2] = MASK_LANE2_RST;
      lane_mask[3] = MASK_LANE3_RST;
      owed_words.delete();
      pending      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_LANE_LEFT_SHIFT:  lshift = cfg_data_i[SHIFT_W-1:0];
          CFG_WORD_LEFT_BYTES:  lbytes = cfg_data_i[SHIFT_W-1:0];
          CFG_LANE_RIGHT_SHIFT: rshift = cfg_data_i[SHIFT_W-1:0];
          CFG_WORD_RIGHT_BYTES: rbytes = cfg_data_i[SHIFT_W-1:0];
          CFG_MASK_LANE0:       lane_mask[0] = cfg_data_i;
          CFG_MASK_LANE1:       lane_mask[1] = cfg_data_i;
          CFG_MASK_LANE2:       lane_mask[2] = cfg_data_i;
          CFG_MASK_LANE3:       lane_mask[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(req_type_i, lane_index_i, seed_word_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("word %h delivered with no draw outstanding", rand_word_i));
        end else begin
          oldest_word = owed_words.pop_front();
          checked++;
          if (rand_word_i !== oldest_word) begin
            report_mismatch($sformatf("word %0d: rand_word %h, predicted %h",
                                      checked, rand_word_i, oldest_word));
          end
        end
      end
      pending = owed_words.size();
    end
  end

endmodule

>>> bench/simd_fast_mersenne_twister_tb.sv
// stimulus and verdict for the sfmt generator: seeding, draws and register settings
// with random idling on both sides; depends on sfmt_pkg, the generator and sfmt_draw_checker
`timescale 1ns / 1ps

module simd_fast_mersenne_twister_tb;
  import sfmt_pkg::*;

  localparam int SETTLE_CYCLES = 600;
  localparam int PHASE_ITEMS   = 16;

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i   = 1'b0;
  logic [INDEX_W-1:0]   lane_index_i = '0;
  logic [LANE_W-1:0]    seed_word_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [LANE_W-1:0]    rand_word_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [LANE_W-1:0]    cfg_data_i   = '0;

  int fail_count;
  int words_pending;
  int words_checked;
  int refills;

  logic        quiet      = 1'b0;
  int unsigned stall_left = 0;
  int          seeds_sent = 0;
  int          draws_sent = 0;
  int          settings   = 0;

  simd_fast_mersenne_twister uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .lane_index_i (lane_index_i),
    .seed_word_i  (seed_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rand_word_o  (rand_word_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  sfmt_draw_checker draw_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .lane_index_i    (lane_index_i),
    .seed_word_i     (seed_word_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rand_word_i     (rand_word_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending),
    .words_checked_o (words_checked),
    .refills_o       (refills)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stalls in random bursts between free-running stretches
  always @(negedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 20);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 9);
    end
  end

  // one request word; entered and left at a falling edge, valid stays high for the next
  task automatic push_request(input req_e req, input logic [INDEX_W-1:0] idx,
                              input logic [LANE_W-1:0] word);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    lane_index_i <= idx;
    seed_word_i  <= word;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    @(negedge clk_i);
    if (req == REQ_SEED) seeds_sent++;
    else draws_sent++;
  endtask

  // draw with random content in the fields the block ignores
  task automatic draw_word();
    push_request(REQ_DRAW, INDEX_W'($urandom_range(0, 1023)), $urandom);
  endtask

  function automatic logic [LANE_W-1:0] pick_seed_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // drain outstanding words, then give the block time to finish any seed write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [LANE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [SHIFT_W-1:0] lls, input logic [SHIFT_W-1:0] wlb,
                               input logic [SHIFT_W-1:0] lrs, input logic [SHIFT_W-1:0] wrb,
                               input logic [LANE_W-1:0] m0, input logic [LANE_W-1:0] m1,
                               input logic [LANE_W-1:0] m2, input logic [LANE_W-1:0] m3);
    wait_idle();
    write_reg(CFG_LANE_LEFT_SHIFT, lls);
    write_reg(CFG_WORD_LEFT_BYTES, wlb);
    write_reg(CFG_LANE_RIGHT_SHIFT, lrs);
    write_reg(CFG_WORD_RIGHT_BYTES, wrb);
    write_reg(CFG_MASK_LANE0, m0);
    write_reg(CFG_MASK_LANE1, m1);
    write_reg(CFG_MASK_LANE2, m2);
    write_reg(CFG_MASK_LANE3, m3);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // mix of draw runs, reseed bursts ending in a draw, and out-of-range seeds
  task automatic run_phase(input int unsigned items);
    int unsigned done;
    int unsigned kind;
    int unsigned len;
    done = 0;
    while (done < items) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        len = $urandom_range(1, 12);
        repeat (len) draw_word();
        done += len;
      end else if (kind < 9) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          push_request(REQ_SEED, INDEX_W'($urandom_range(0, LANES - 1)), pick_seed_word());
        end
        draw_word();
        done += len + 1;
      end else begin
        push_request(REQ_SEED, INDEX_W'($urandom_range(LANES, 1023)), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every lane seeded with zero so the first draw meets the all-zero state
    for (int k = 0; k < LANES; k++) push_request(REQ_SEED, INDEX_W'(k), '0);

    // directed: zero guard, out-of-range seed, index and word extremes
    draw_word();
    draw_word();
    draw_word();
    push_request(REQ_SEED, 10'd1023, '1);
    draw_word();
    push_request(REQ_SEED, 10'd0, '1);
    push_request(REQ_SEED, 10'd623, '0);
    push_request(REQ_SEED, 10'd624, 32'h1234_5678);
    draw_word();
    push_request(REQ_SEED, 10'd512, 32'haaaa_aaaa);
    push_request(REQ_SEED, 10'd511, 32'h5555_5555);
    draw_word();
    draw_word();
    draw_word();

    // all shifts and masks at zero
    load_settings('0, '0, '0, '0, '0, '0, '0, '0);
    run_phase(PHASE_ITEMS);

    // top extremes, byte shifts at and past the word width
    load_settings(5'd31, 5'd16, 5'd31, 5'd31, '1, '1, '1, '1);
    run_phase(PHASE_ITEMS);

    // random setting
    load_settings(SHIFT_W'($urandom_range(0, 31)), SHIFT_W'($urandom_range(0, 31)),
                  SHIFT_W'($urandom_range(0, 31)), SHIFT_W'($urandom_range(0, 31)),
                  $urandom, $urandom, $urandom, $urandom);
    run_phase(PHASE_ITEMS);

    // back to the power-on setting, idling stops for the final stretch
    load_settings(LANE_LEFT_SHIFT_RST, WORD_LEFT_BYTES_RST, LANE_RIGHT_SHIFT_RST,
                  WORD_RIGHT_BYTES_RST, MASK_LANE0_RST, MASK_LANE1_RST, MASK_LANE2_RST,
                  MASK_LANE3_RST);
    run_phase(PHASE_ITEMS / 2);
    quiet = 1'b1;
    run_phase(PHASE_ITEMS / 2);

    wait_idle();
    if (words_pending != 0) begin
      $display("%0d predicted words never delivered", words_pending);
    end
    $display("sent %0d seed writes and %0d draws under %0d register settings plus power-on",
             seeds_sent, draws_sent, settings);
    $display("checked %0d words across %0d lane store refills", words_checked, refills);
    if (fail_count == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("watchdog expired with %0d words outstanding", words_pending);
    $display("simulation failed");
    $finish;
  end

endmodule
